// ===== hw/rtl/lkc_pkg.sv =====
`timescale 1ns / 1ps
package lkc_pkg;

	// Width and reset value of the capacity register.
	localparam int CAP_BITS = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	// Width of the key field.
	localparam int KEY_BITS = 64;

	// Operation codes of the request word.
	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_INSERT = 1'b1
	} cmd_t;

	// Broadcast control from the top level to every cell.
	typedef struct packed {
		logic lookup_go;  // accepted lookup that hits somewhere in the row
		logic insert_go;  // accepted insert whose key is not present
		logic evict;      // the insert drops the least recent entry
	} cell_cmd_t;

endpackage

// ===== hw/rtl/lkc_if.sv =====
`timescale 1ns / 1ps

// Request channel: one lookup or insert word.
interface lkc_req_if #(
	parameter int HANDLE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [lkc_pkg::KEY_BITS-1:0] key;
	logic [HANDLE_BITS-1:0]        handle;

	modport source (output valid, output cmd, output key, output handle, input ready);
	modport sink (input valid, input cmd, input key, input handle, output ready);
endinterface

// Response channel: one result word per request word.
interface lkc_rsp_if #(
	parameter int HANDLE_BITS = 32
);
	logic                   valid;
	logic                   ready;
	logic                   ok;
	logic [HANDLE_BITS-1:0] hit_handle;
	logic                   evicted;

	modport source (output valid, output ok, output hit_handle, output evicted, input ready);
	modport sink (input valid, input ok, input hit_handle, input evicted, output ready);
endinterface

// Configuration channel: writes the capacity register.
interface lkc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lkc_pkg::CAP_BITS-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lkc_cell.sv =====
`timescale 1ns / 1ps

// One entry of the recency-ordered row. Cell position equals recency rank,
// so the head cell holds the most recent entry. On a load the cell takes
// the entry of its upstream neighbor.
module lkc_cell #(
	parameter int HANDLE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkc_pkg::cell_cmd_t            cmd,
	input  logic [lkc_pkg::KEY_BITS-1:0] search_key,
	input  logic [lkc_pkg::KEY_BITS-1:0] prev_key,
	input  logic [HANDLE_BITS-1:0]        prev_handle,
	input  logic                          prev_valid,
	input  logic                          hit_in,
	input  logic [HANDLE_BITS-1:0]        hsel_in,
	output logic [lkc_pkg::KEY_BITS-1:0] key_q,
	output logic [HANDLE_BITS-1:0]        handle_q,
	output logic                          valid_q,
	output logic                          hit_out,
	output logic [HANDLE_BITS-1:0]        hsel_out
);
	import lkc_pkg::*;

	logic match;
	logic load;
	logic drop;

	// Key compare and the running hit and handle select along the row.
	assign match    = valid_q && (key_q == search_key);
	assign hit_out  = hit_in | match;
	assign hsel_out = hsel_in | (match ? handle_q : '0);

	// A lookup hit shifts every cell up to and including the hit position;
	// an insert shifts the whole row.
	assign load = (cmd.lookup_go && !hit_in) || cmd.insert_go;

	// On an eviction the last valid entry is the one upstream of the first
	// empty cell, and it does not move on.
	assign drop = cmd.insert_go && cmd.evict && !valid_q;

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= prev_valid && !drop;
		end
	end

	// Entry contents.
	always_ff @(posedge clk) begin
		if (load) begin
			key_q    <= prev_key;
			handle_q <= prev_handle;
		end
	end

endmodule

// ===== hw/rtl/lru_keyed_cache_top.sv =====
`timescale 1ns / 1ps
// A result word is registered in the cycle after its request word is accepted.
// One request word per cycle while result words are taken; the whole row of
// cells compares the key and shifts in the same cycle, and an untaken result
// word stalls requests. Reset: all entries become invalid, occupancy is zero,
// capacity reads 16 and the result register is empty. Contents stay uncleared.
module lru_keyed_cache_top #(
	parameter int ENTRIES     = 16,
	parameter int HANDLE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	lkc_req_if.sink   req,
	lkc_rsp_if.source rsp,
	lkc_cfg_if.sink   cfg
);
	import lkc_pkg::*;

	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;

	logic [CAP_BITS-1:0]    cap_q;
	logic [OCC_W-1:0]       occ_q;
	logic                   rsp_valid_q;
	logic                   ok_q;
	logic [HANDLE_BITS-1:0] hit_handle_q;
	logic                   evicted_q;

	logic                   accept;
	logic                   is_insert;
	logic [CMP_W-1:0]       eff_cap;
	logic                   full;
	logic                   any_hit;
	logic [HANDLE_BITS-1:0] hit_sel;
	logic [HANDLE_BITS-1:0] head_handle;
	cell_cmd_t              cell_cmd;

	logic [KEY_BITS-1:0]    key_c    [ENTRIES];
	logic [HANDLE_BITS-1:0] handle_c [ENTRIES];
	logic                   valid_c  [ENTRIES];
	logic                   hit_ch   [ENTRIES+1];
	logic [HANDLE_BITS-1:0] hsel_ch  [ENTRIES+1];

	// Handshakes.
	assign accept    = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;
	assign is_insert = (req.cmd == CMD_INSERT);

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cap_q <= cfg.data;
		end
	end

	// Effective capacity, clamped to the range one to ENTRIES.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
	end
	assign full = CMP_W'(occ_q) >= eff_cap;

	// Broadcast control to the row.
	assign any_hit            = hit_ch[ENTRIES];
	assign hit_sel            = hsel_ch[ENTRIES];
	assign cell_cmd.lookup_go = accept && !is_insert && any_hit;
	assign cell_cmd.insert_go = accept && is_insert && !any_hit;
	assign cell_cmd.evict     = full;

	// The head cell takes the new pair on an insert, the hit pair on a lookup.
	assign head_handle = is_insert ? req.handle : hit_sel;

	assign hit_ch[0]  = 1'b0;
	assign hsel_ch[0] = '0;

	// Row of cells, most recent first.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic [KEY_BITS-1:0]    prev_key;
		logic [HANDLE_BITS-1:0] prev_handle;
		logic                   prev_valid;

		if (i == 0) begin : g_head
			assign prev_key    = req.key;
			assign prev_handle = head_handle;
			assign prev_valid  = 1'b1;
		end else begin : g_body
			assign prev_key    = key_c[i-1];
			assign prev_handle = handle_c[i-1];
			assign prev_valid  = valid_c[i-1];
		end

		lkc_cell #(
			.HANDLE_BITS(HANDLE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cell_cmd),
			.search_key (req.key),
			.prev_key   (prev_key),
			.prev_handle(prev_handle),
			.prev_valid (prev_valid),
			.hit_in     (hit_ch[i]),
			.hsel_in    (hsel_ch[i]),
			.key_q      (key_c[i]),
			.handle_q   (handle_c[i]),
			.valid_q    (valid_c[i]),
			.hit_out    (hit_ch[i+1]),
			.hsel_out   (hsel_ch[i+1])
		);
	end

	// Occupancy grows on an insert that does not evict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cell_cmd.insert_go && !full) begin
			occ_q <= occ_q + OCC_W'(1);
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q         <= is_insert ? !any_hit : any_hit;
			hit_handle_q <= is_insert ? '0 : hit_sel;
			evicted_q    <= is_insert && !any_hit && full;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.ok         = ok_q;
	assign rsp.hit_handle = hit_handle_q;
	assign rsp.evicted    = evicted_q;

endmodule

// ===== hw/rtl/lkc_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks for the cache.
module lkc_checker #(
	parameter int HANDLE_BITS = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic                   rsp_ok,
	input logic [HANDLE_BITS-1:0] rsp_hit_handle,
	input logic                   rsp_evicted
);

	// A pending result word stays until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped before it was taken");

	// Every accepted request yields a result word in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no result word after an accepted request");

	// An empty result register never stalls the request side.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with an empty result register");

	// An eviction happens only on a stored insert.
	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_evicted |-> rsp_ok)
		else $error("eviction reported on a refused insert");

	// A returned handle comes only with a lookup hit, never with an eviction.
	a_handle_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_hit_handle != '0) |-> rsp_ok && !rsp_evicted)
		else $error("handle returned without a lookup hit");

endmodule

bind lru_keyed_cache_top lkc_checker #(
	.HANDLE_BITS(HANDLE_BITS)
) u_lkc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_ok        (rsp.ok),
	.rsp_hit_handle(rsp.hit_handle),
	.rsp_evicted   (rsp.evicted)
);
